// ===== rtl/sorted_priority_queue_multikey_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_MULTIKEY_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_MULTIKEY_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq check failed: same-cycle property");

// Check a consequent in the cycle after its antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq check failed: next-cycle property");

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [31:0] in_price;
    logic [15:0] in_weight;
    logic [15:0] in_sensor;
    logic [63:0] in_model;
    logic [15:0] in_tag;
  } in_t;

  typedef struct packed {
    logic        out_valid;
    logic [31:0] out_price;
    logic [15:0] out_weight;
    logic [15:0] out_sensor;
    logic [63:0] out_model;
    logic [15:0] out_tag;
    logic [1:0]  op_status;
    logic [4:0]  fill_level;
  } out_t;

  typedef struct packed {
    logic [31:0] price;
    logic [15:0] weight;
    logic [15:0] sensor;
    logic [63:0] model;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INS,
    S_POP
  } state_t;

  // True when stored entry a ranks below key b.
  function automatic logic ranks_below(entry_t a, entry_t b);
    logic r;
    if (a.price != b.price) r = a.price < b.price;
    else if (a.weight != b.weight) r = a.weight < b.weight;
    else if (a.sensor != b.sensor) r = a.sensor < b.sensor;
    else r = a.model > b.model;
    return r;
  endfunction

endpackage

// ===== rtl/spq_mem.sv =====
module spq_mem import spq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  // Write one entry, read one entry with a registered output.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sorted_priority_queue_multikey_top.sv =====
// Sorted priority queue with a compound key, held in one entry memory.
// Input: drive in_data and raise start while busy is low; the transaction
// is taken at that edge. in_data.func selects push or pop.
// Output: each transaction yields exactly one result, shown on out_data for
// one cycle with out_strobe high. The receiver cannot stall the block.
// Push on an empty or full queue, and pop on an empty queue, give the
// result in the cycle after start. A pop reads the top entry, then returns
// it from S_POP. A push into a queue neither empty nor full scans for its place:
// the scan walks down from the top, one memory read and one shifting write
// per cycle through the single read port and single write port.
// busy stays high until the result strobe; a new start is taken in the
// cycle of the strobe at the earliest.
// Reset (synchronous, rst_n low) empties the queue at once; memory
// contents are not cleared, since only entries below the count are read.
module sorted_priority_queue_multikey_top import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_strobe,
  output out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] k_r, k_nxt;
  entry_t        new_r, new_nxt;
  out_t          out_r, out_nxt;
  logic          strobe_r, strobe_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata, in_entry;

  spq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_entry = '{price: in_data.in_price, weight: in_data.in_weight,
                      sensor: in_data.in_sensor, model: in_data.in_model,
                      tag: in_data.in_tag};

  // Hold control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Hold payload.
  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    new_r <= new_nxt;
    out_r <= out_nxt;
  end

  // Sequence scan, shift, insert and pop.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    new_nxt    = new_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    we         = 1'b0;
    waddr      = k_r;
    wdata      = new_r;
    raddr      = AW'(count_r - CW'(1));
    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_nxt = '0;
          if (in_data.func == FUNC_PUSH) begin
            new_nxt = in_entry;
            if (count_r == CW'(DEPTH)) begin
              strobe_nxt         = 1'b1;
              out_nxt.op_status  = ST_FULL;
              out_nxt.fill_level = 5'(count_r);
            end else if (count_r == '0) begin
              we                 = 1'b1;
              waddr              = '0;
              wdata              = in_entry;
              count_nxt          = CW'(1);
              strobe_nxt         = 1'b1;
              out_nxt.op_status  = ST_OK;
              out_nxt.fill_level = 5'd1;
            end else begin
              k_nxt     = AW'(count_r - CW'(1));
              state_nxt = S_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              strobe_nxt         = 1'b1;
              out_nxt.op_status  = ST_EMPTY;
              out_nxt.fill_level = 5'(count_r);
            end else begin
              state_nxt = S_POP;
            end
          end
        end
      end
      S_SCAN: begin
        we    = 1'b1;
        waddr = k_r + AW'(1);
        if (ranks_below(rdata, new_r)) begin
          wdata              = new_r;
          count_nxt          = count_r + CW'(1);
          strobe_nxt         = 1'b1;
          out_nxt.op_status  = ST_OK;
          out_nxt.fill_level = 5'(count_r + CW'(1));
          state_nxt          = S_IDLE;
        end else begin
          wdata = rdata;
          if (k_r == '0) begin
            state_nxt = S_INS;
          end else begin
            raddr = k_r - AW'(1);
            k_nxt = k_r - AW'(1);
          end
        end
      end
      S_INS: begin
        we                 = 1'b1;
        waddr              = '0;
        wdata              = new_r;
        count_nxt          = count_r + CW'(1);
        strobe_nxt         = 1'b1;
        out_nxt.op_status  = ST_OK;
        out_nxt.fill_level = 5'(count_r + CW'(1));
        state_nxt          = S_IDLE;
      end
      S_POP: begin
        count_nxt          = count_r - CW'(1);
        strobe_nxt         = 1'b1;
        out_nxt.out_valid  = 1'b1;
        out_nxt.out_price  = rdata.price;
        out_nxt.out_weight = rdata.weight;
        out_nxt.out_sensor = rdata.sensor;
        out_nxt.out_model  = rdata.model;
        out_nxt.out_tag    = rdata.tag;
        out_nxt.op_status  = ST_OK;
        out_nxt.fill_level = 5'(count_r - CW'(1));
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

// ===== rtl/spq_checker.sv =====
`include "sorted_priority_queue_multikey_top_assert.svh"

module spq_checker import spq_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input out_t out_data
);

  logic zero_data;

  // Flag a result whose data fields are all zero.
  assign zero_data = (out_data.out_price == '0) && (out_data.out_weight == '0) &&
                     (out_data.out_sensor == '0) && (out_data.out_model == '0) &&
                     (out_data.out_tag == '0);

  // A returned entry always reports success.
  `SPQ_ASSERT_NOW(a_valid_ok, out_strobe && out_data.out_valid, out_data.op_status == ST_OK)
  // Results without an entry carry zero data.
  `SPQ_ASSERT_NOW(a_zero_data, out_strobe && !out_data.out_valid, zero_data)
  // An accepted transaction either completes or keeps the block busy.
  `SPQ_ASSERT_NEXT(a_start_busy, start && !busy, busy || out_strobe)
  // The block is free again when its result appears.
  `SPQ_ASSERT_NOW(a_strobe_idle, out_strobe, !busy)

endmodule

bind sorted_priority_queue_multikey_top spq_checker u_spq_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_data(out_data)
);
